FILE: src/sorted_timer_queue_assert.svh
// Assertion macros shared by the timer queue RTL
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Same-cycle check: when a holds, c holds on that edge
`define STQ_ASSERT_NOW(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("timer queue check failed");

// Next-cycle check: when a holds, c holds on the following edge
`define STQ_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("timer queue check failed");

`endif

FILE: src/stq_pkg.sv
// Types and constants of the sorted timer queue
package stq_pkg;

    localparam int DL_W   = 40;
    localparam int ID_W   = 32;
    localparam int HDL_W  = 8;
    localparam int TOK_W  = 32;
    localparam int DLY_W  = 20;
    localparam int PROD_W = 30;

    localparam logic [9:0]      US_PER_MS = 10'd1000;
    localparam logic [DL_W-1:0] DL_MAX    = {DL_W{1'b1}};

    // request codes
    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // result kinds
    localparam logic [2:0] K_ARMED     = 3'd0;
    localparam logic [2:0] K_FIRED     = 3'd1;
    localparam logic [2:0] K_CANCELLED = 3'd2;
    localparam logic [2:0] K_NOTFOUND  = 3'd3;
    localparam logic [2:0] K_FULL      = 3'd4;
    localparam logic [2:0] K_DONE      = 3'd5;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [HDL_W-1:0] handler;
        logic [TOK_W-1:0] token;
        logic [ID_W-1:0]  id;
    } t_entry;

    typedef struct packed {
        logic [2:0]       kind;
        logic [ID_W-1:0]  id;
        logic [HDL_W-1:0] handler;
        logic [TOK_W-1:0] token;
        logic [DL_W-1:0]  ttn;
        logic             pending;
        logic             last;
    } t_result;

endpackage

FILE: src/sorted_timer_queue.sv
// Sorted timer queue: arm searches from the last entry down, cancel searches
// by id and closes the gap, tick fires due timers from the head and closes with a done result;
// each table step is a read then a write of the entry memory; an output stall holds the sequence.
// Results leave through an output register; the next request is taken once
// the last result is loaded. Synchronous active-low reset empties the table
// and sets the next id to 1; memory contents are not cleared.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [DL_W-1:0]     i_current_time,
    input  logic [DLY_W-1:0]    i_delay_ms,
    input  logic [HDL_W-1:0]    i_handler,
    input  logic [TOK_W-1:0]    i_token,
    input  logic [ID_W-1:0]     i_timer_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_kind,
    output logic [ID_W-1:0]     o_result_id,
    output logic [HDL_W-1:0]    o_fired_handler,
    output logic [TOK_W-1:0]    o_fired_token,
    output logic [DL_W-1:0]     o_time_to_next,
    output logic                o_pending,
    output logic                o_last
);

`include "sorted_timer_queue_assert.svh"

    localparam int AW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_ARM_CALC = 12'b000000000010,
        S_ARM_RD   = 12'b000000000100,
        S_ARM_CMP  = 12'b000000001000,
        S_ARM_PUT  = 12'b000000010000,
        S_CAN_RD   = 12'b000000100000,
        S_CAN_CMP  = 12'b000001000000,
        S_SH_RD    = 12'b000010000000,
        S_SH_WR    = 12'b000100000000,
        S_TK_RD    = 12'b001000000000,
        S_TK_CMP   = 12'b010000000000,
        S_EMIT     = 12'b100000000000
    } t_state;

    // control state
    t_state        r_state, n_state;
    t_state        r_after, n_after;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [ID_W-1:0] r_next_id, n_next_id;
    logic          r_sh_cancel, n_sh_cancel;
    logic          r_ov;

    // request and work registers
    logic [DL_W-1:0]   r_now;
    logic [PROD_W-1:0] r_prod;
    logic [DL_W-1:0]   r_dl, n_dl;
    logic [HDL_W-1:0]  r_hdl;
    logic [TOK_W-1:0]  r_tok;
    logic [ID_W-1:0]   r_tid;
    logic [CW-1:0]     r_pos, n_pos;
    t_result           r_res, n_res;
    t_result           r_out;

    // memory port
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_entry        wr_data, rd_data;

    logic          in_acc, out_free;
    logic [CW-1:0] idx_inc;
    logic [DL_W:0] dl_sum;

    stq_entry_ram #(.DEPTH(TIMER_SLOTS), .AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign idx_inc    = r_idx + CW'(1);
    assign dl_sum     = {1'b0, r_now} + {{(DL_W + 1 - PROD_W){1'b0}}, r_prod};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_count     = r_count;
        n_idx       = r_idx;
        n_next_id   = r_next_id;
        n_sh_cancel = r_sh_cancel;
        n_dl        = r_dl;
        n_pos       = r_pos;
        n_res       = r_res;
        wr_en       = 1'b0;
        wr_addr     = r_idx[AW-1:0];
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    unique case (i_op)
                        OP_ARM:    n_state = S_ARM_CALC;
                        OP_CANCEL: n_state = S_CAN_RD;
                        OP_TICK:   n_state = S_TK_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ARM_CALC: begin
                n_res = '0;
                n_res.last = 1'b1;
                n_dl  = dl_sum[DL_W] ? DL_MAX : dl_sum[DL_W-1:0];
                if (r_count == CW'(TIMER_SLOTS)) begin
                    n_res.kind = K_FULL;
                    n_after    = S_IDLE;
                    n_state    = S_EMIT;
                end else if (r_count == '0) begin
                    n_pos   = '0;
                    n_state = S_ARM_PUT;
                end else begin
                    n_idx   = r_count - CW'(1);
                    n_state = S_ARM_RD;
                end
            end
            S_ARM_RD: begin
                rd_en   = 1'b1;
                n_state = S_ARM_CMP;
            end
            // later deadlines move up one slot; stop at an equal or earlier one
            S_ARM_CMP: begin
                if (rd_data.deadline > r_dl) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_inc[AW-1:0];
                    if (r_idx == '0) begin
                        n_pos   = '0;
                        n_state = S_ARM_PUT;
                    end else begin
                        n_idx   = r_idx - CW'(1);
                        n_state = S_ARM_RD;
                    end
                end else begin
                    n_pos   = idx_inc;
                    n_state = S_ARM_PUT;
                end
            end
            S_ARM_PUT: begin
                wr_en            = 1'b1;
                wr_addr          = r_pos[AW-1:0];
                wr_data.deadline = r_dl;
                wr_data.handler  = r_hdl;
                wr_data.token    = r_tok;
                wr_data.id       = r_next_id;
                n_count          = r_count + CW'(1);
                n_next_id        = r_next_id + ID_W'(1);
                n_res            = '0;
                n_res.kind       = K_ARMED;
                n_res.id         = r_next_id;
                n_res.last       = 1'b1;
                n_after          = S_IDLE;
                n_state          = S_EMIT;
            end
            S_CAN_RD: begin
                if (r_idx == r_count) begin
                    n_res      = '0;
                    n_res.kind = K_NOTFOUND;
                    n_res.id   = r_tid;
                    n_res.last = 1'b1;
                    n_after    = S_IDLE;
                    n_state    = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_CAN_CMP;
                end
            end
            S_CAN_CMP: begin
                if (rd_data.id == r_tid) begin
                    n_sh_cancel = 1'b1;
                    n_state     = S_SH_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_CAN_RD;
                end
            end
            // close the gap at r_idx, one entry per read/write pair
            S_SH_RD: begin
                if (idx_inc < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[AW-1:0];
                    n_state = S_SH_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    if (r_sh_cancel) begin
                        n_res      = '0;
                        n_res.kind = K_CANCELLED;
                        n_res.id   = r_tid;
                        n_res.last = 1'b1;
                        n_after    = S_IDLE;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_TK_RD;
                    end
                end
            end
            S_SH_WR: begin
                wr_en   = 1'b1;
                n_idx   = idx_inc;
                n_state = S_SH_RD;
            end
            S_TK_RD: begin
                n_idx = '0;
                if (r_count == '0) begin
                    n_res      = '0;
                    n_res.kind = K_DONE;
                    n_res.last = 1'b1;
                    n_after    = S_IDLE;
                    n_state    = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_state = S_TK_CMP;
                end
            end
            S_TK_CMP: begin
                n_res = '0;
                if (rd_data.deadline <= r_now) begin
                    n_res.kind    = K_FIRED;
                    n_res.id      = rd_data.id;
                    n_res.handler = rd_data.handler;
                    n_res.token   = rd_data.token;
                    n_sh_cancel   = 1'b0;
                    n_after       = S_SH_RD;
                end else begin
                    n_res.kind    = K_DONE;
                    n_res.ttn     = rd_data.deadline - r_now;
                    n_res.pending = 1'b1;
                    n_res.last    = 1'b1;
                    n_after       = S_IDLE;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_after;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_next_id   <= ID_W'(1);
            r_sh_cancel <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_next_id   <= n_next_id;
            r_sh_cancel <= n_sh_cancel;
            if (r_state == S_EMIT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now  <= i_current_time;
            r_prod <= i_delay_ms * US_PER_MS;
            r_hdl  <= i_handler;
            r_tok  <= i_token;
            r_tid  <= i_timer_id;
        end
        r_dl  <= n_dl;
        r_pos <= n_pos;
        r_res <= n_res;
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_kind          = r_out.kind;
    assign o_result_id     = r_out.id;
    assign o_fired_handler = r_out.handler;
    assign o_fired_token   = r_out.token;
    assign o_time_to_next  = r_out.ttn;
    assign o_pending       = r_out.pending;
    assign o_last          = r_out.last;

    `STQ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(TIMER_SLOTS))
    `STQ_ASSERT_NOW(a_wr_in_table, i_clk, i_rst_n, wr_en, {1'b0, wr_addr} < (AW + 1)'(TIMER_SLOTS))
    `STQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && o_kind == $past(o_kind))
    `STQ_ASSERT_NEXT(a_arm_grows, i_clk, i_rst_n, r_state == S_ARM_PUT, r_count == $past(r_count) + CW'(1))

endmodule

FILE: src/stq_entry_ram.sv
// Timer entry memory: one write port, one registered read port
module stq_entry_ram
    import stq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: dv/tb.sv
// Testbench for sorted_timer_queue: directed, random, back-pressure and streaming request streams
`timescale 1ns / 100ps

module tb;
    import stq_pkg::*;

    localparam int SLOTS    = 16;
    localparam int HOLD_CYC = 300;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_op = OP_TICK;
    logic [DL_W-1:0]   i_current_time = '0;
    logic [DLY_W-1:0]  i_delay_ms = '0;
    logic [HDL_W-1:0]  i_handler = '0;
    logic [TOK_W-1:0]  i_token = '0;
    logic [ID_W-1:0]   i_timer_id = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [2:0]        o_kind;
    logic [ID_W-1:0]   o_result_id;
    logic [HDL_W-1:0]  o_fired_handler;
    logic [TOK_W-1:0]  o_fired_token;
    logic [DL_W-1:0]   o_time_to_next;
    logic              o_pending;
    logic              o_last;

    sorted_timer_queue #(.TIMER_SLOTS(SLOTS)) u_top (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the timer table, and results still owed by the block
    t_entry          timer_table[$];
    logic [ID_W-1:0] id_counter = 1;
    t_result         owed_results[$];

    bit       no_idle = 1'b0;
    bit       hold_out = 1'b0;
    int       fail_count = 0;
    int       n_requests = 0;
    int       n_results = 0;
    int       n_fired = 0;
    int       n_full = 0;
    logic [DL_W-1:0] clock_us = '0;

    // compute what one request does to the table and what it returns
    task automatic apply_request(input logic [1:0] op, input logic [DL_W-1:0] now,
                                 input logic [DLY_W-1:0] dly, input logic [HDL_W-1:0] h,
                                 input logic [TOK_W-1:0] tok, input logic [ID_W-1:0] tid);
        t_result r;
        t_entry  e;
        logic [63:0] sum;
        int pos;
        bit hit;
        r = '0;
        r.last = 1'b1;
        case (op)
            OP_ARM: begin
                if (timer_table.size() >= SLOTS) begin
                    r.kind = K_FULL;
                    n_full++;
                end else begin
                    sum = 64'(now) + 64'(dly) * 64'd1000;
                    e.deadline = (sum > 64'(DL_MAX)) ? DL_MAX : sum[DL_W-1:0];
                    e.handler = h;
                    e.token = tok;
                    e.id = id_counter;
                    pos = 0;
                    while (pos < timer_table.size() && !(e.deadline < timer_table[pos].deadline))
                        pos++;
                    timer_table.insert(pos, e);
                    r.kind = K_ARMED;
                    r.id = id_counter;
                    id_counter = id_counter + 1;
                end
                owed_results.push_back(r);
            end
            OP_CANCEL: begin
                hit = 1'b0;
                pos = 0;
                for (int i = 0; i < timer_table.size(); i++) begin
                    if (!hit && timer_table[i].id == tid) begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                if (hit)
                    timer_table.delete(pos);
                r.kind = hit ? K_CANCELLED : K_NOTFOUND;
                r.id = tid;
                owed_results.push_back(r);
            end
            OP_TICK: begin
                while (timer_table.size() > 0 && timer_table[0].deadline <= now) begin
                    e = timer_table.pop_front();
                    r = '0;
                    r.kind = K_FIRED;
                    r.id = e.id;
                    r.handler = e.handler;
                    r.token = e.token;
                    owed_results.push_back(r);
                    n_fired++;
                end
                r = '0;
                r.kind = K_DONE;
                r.last = 1'b1;
                if (timer_table.size() > 0) begin
                    r.ttn = timer_table[0].deadline - now;
                    r.pending = 1'b1;
                end
                owed_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // offer one request, hold it until taken, then maybe pause
    task automatic send_request(input logic [1:0] op, input logic [DL_W-1:0] now,
                                input logic [DLY_W-1:0] dly, input logic [HDL_W-1:0] h,
                                input logic [TOK_W-1:0] tok, input logic [ID_W-1:0] tid);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_current_time <= now;
        i_delay_ms <= dly;
        i_handler <= h;
        i_token <= tok;
        i_timer_id <= tid;
        do @(posedge i_clk); while (o_in_stall);
        apply_request(op, now, dly, h, tok, tid);
        n_requests++;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // result stall: random bursts, or a long hold, or none at the end
    int stall_left = 0;
    int run_left = 0;
    always @(posedge i_clk) begin
        if (hold_out) begin
            i_out_stall <= 1'b1;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_out_stall <= 1'b1;
        end else begin
            run_left = $urandom_range(1, 12) - 1;
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result x;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (owed_results.size() == 0) begin
                $error("unexpected result kind=%0d id=%0h", o_kind, o_result_id);
                fail_count++;
            end else begin
                x = owed_results.pop_front();
                if (o_kind !== x.kind) begin
                    $error("kind: expected %0d, got %0d", x.kind, o_kind);
                    fail_count++;
                end
                if (o_result_id !== x.id) begin
                    $error("result_id: expected %0h, got %0h", x.id, o_result_id);
                    fail_count++;
                end
                if (o_fired_handler !== x.handler) begin
                    $error("fired_handler: expected %0h, got %0h", x.handler,
                           o_fired_handler);
                    fail_count++;
                end
                if (o_fired_token !== x.token) begin
                    $error("fired_token: expected %0h, got %0h", x.token, o_fired_token);
                    fail_count++;
                end
                if (o_time_to_next !== x.ttn) begin
                    $error("time_to_next: expected %0h, got %0h", x.ttn, o_time_to_next);
                    fail_count++;
                end
                if (o_pending !== x.pending) begin
                    $error("pending: expected %0b, got %0b", x.pending, o_pending);
                    fail_count++;
                end
                if (o_last !== x.last) begin
                    $error("last: expected %0b, got %0b", x.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // one random request around the running clock
    task automatic random_request(input int arm_weight);
        int pick;
        logic [DLY_W-1:0] dly;
        logic [ID_W-1:0] tid;
        pick = $urandom_range(0, 99);
        clock_us = clock_us + DL_W'($urandom_range(0, 4000));
        if ($urandom_range(0, 49) == 0)
            clock_us = DL_W'({$urandom, $urandom});
        if (pick < arm_weight) begin
            dly = ($urandom_range(0, 19) == 0) ? DLY_W'($urandom) : DLY_W'($urandom_range(0, 12));
            send_request(OP_ARM, clock_us, dly, HDL_W'($urandom), $urandom, $urandom);
        end else if (pick < arm_weight + 20) begin
            if (timer_table.size() > 0 && $urandom_range(0, 3) != 0)
                tid = timer_table[$urandom_range(0, timer_table.size() - 1)].id;
            else
                tid = $urandom;
            send_request(OP_CANCEL, clock_us, DLY_W'($urandom), HDL_W'($urandom),
                         $urandom, tid);
        end else if (pick < 97) begin
            send_request(OP_TICK, clock_us, DLY_W'($urandom), HDL_W'($urandom),
                         $urandom, $urandom);
        end else begin
            send_request(2'd3, clock_us, DLY_W'($urandom), HDL_W'($urandom),
                         $urandom, $urandom);
        end
    endtask

    // edge values, equal deadlines, saturation, full table, a tick that fires all
    task automatic test_directed();
        send_request(OP_TICK, '0, '0, '0, '0, '0);
        send_request(OP_ARM, 40'd1000, '0, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_ARM, 40'd1000, '0, 8'h00, 32'h0, 32'h0);
        send_request(OP_ARM, '0, 20'd1, 8'h5a, 32'h1234_5678, 32'h0);
        send_request(OP_ARM, DL_MAX, DLY_W'('1), 8'ha5, 32'hdead_beef, 32'h0);
        send_request(OP_ARM, 40'd10, DLY_W'('1), 8'h11, 32'h2, 32'h0);
        send_request(OP_CANCEL, '0, '0, '0, '0, 32'd3);
        send_request(OP_CANCEL, '0, '0, '0, '0, 32'hffff_ffff);
        send_request(OP_CANCEL, '0, '0, '0, '0, 32'h0);
        send_request(2'd3, DL_MAX, DLY_W'('1), 8'hff, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_TICK, 40'd999, '0, '0, '0, '0);
        send_request(OP_TICK, 40'd1000, '0, '0, '0, '0);
        while (timer_table.size() < SLOTS)
            send_request(OP_ARM, 40'd5000, DLY_W'($urandom_range(0, 3)), HDL_W'($urandom),
                         $urandom, '0);
        send_request(OP_ARM, '0, '0, 8'h77, 32'h7, '0);
        send_request(OP_TICK, DL_MAX, '0, '0, '0, '0);
        clock_us = '0;
    endtask

    // mostly well-formed traffic with varied mix
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            random_request((i % 100 < 50) ? 60 : 35);
    endtask

    // receiver holds off long enough to fill the block and stall its input
    task automatic test_backpressure();
        fork
            begin
                hold_out = 1'b1;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_out = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                random_request(50);
        join
    endtask

    // final stretch with no idling on either side
    task automatic test_streaming();
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++)
            random_request(45);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(340);
        test_backpressure();
        test_streaming();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d requests, %0d results checked (%0d fired, %0d table-full refusals)",
                 n_requests, n_results, n_fired, n_full);
        if (fail_count == 0)
            $display("sorted_timer_queue verification clean");
        else
            $display("sorted_timer_queue verification failed");
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("sorted_timer_queue verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/stq_pkg.sv
src/stq_entry_ram.sv
src/sorted_timer_queue.sv
dv/tb.sv
